// ===== sv/vmmf_pkg.sv =====
`default_nettype none

package vmmf_pkg;

   // operation carried in req_tuser
   typedef enum logic [1:0] {
      OP_MIX      = 2'd0,
      OP_TICK     = 2'd1,
      OP_FADE_IN  = 2'd2,
      OP_FADE_OUT = 2'd3
   } op_type;

   // fade state as reported in the result item
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_IN   = 2'd1,
      MODE_OUT  = 2'd2
   } mode_type;

   // q1.15 gain constants
   localparam logic [15:0] GAIN_ONE   = 16'd32768;
   localparam logic [15:0] GAIN_HALF  = 16'd16384;
   localparam logic [15:0] STEP_RESET = 16'd298;

   // control from the input stage to the fade unit
   typedef struct packed {
      logic   fire;
      op_type op;
   } fade_ctl_type;

   // gain and mode after an item
   typedef struct packed {
      logic [15:0] gain;
      mode_type    mode;
   } fade_sts_type;

   // knee base per magnitude segment
   function automatic logic [15:0] knee_base(input logic [2:0] seg);
      logic [15:0] base;
      case (seg)
         3'd0:    base = 16'd0;
         3'd1:    base = 16'd28672;
         3'd2:    base = 16'd32256;
         3'd3:    base = 16'd32704;
         default: base = 16'd32760;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

// ===== sv/vmmf_mix.sv =====
`default_nettype none

module vmmf_mix (
   input  wire logic signed [15:0] voice_sample,
   input  wire logic signed [15:0] music_sample,
   input  wire logic        [15:0] gain,
   output logic signed      [15:0] mixed_sample
);

   logic signed [32:0] prod_w;
   logic signed [32:0] bias_w;
   logic signed [32:0] biased_w;
   logic signed [17:0] scaled_w;
   logic signed [17:0] sum_w;
   logic        [16:0] mag_w;
   logic        [2:0]  seg_w;
   logic        [17:0] rem7_w;
   logic        [17:0] shifted_w;
   logic        [15:0] res_w;

   // music times gain, truncated toward zero
   always_comb begin
      prod_w   = music_sample * $signed({1'b0, gain});
      bias_w   = prod_w[32] ? 33'sd32767 : 33'sd0;
      biased_w = prod_w + bias_w;
      scaled_w = biased_w[32:15];
   end

   // sum and magnitude split into segment and remainder
   always_comb begin
      sum_w  = {{2{voice_sample[15]}}, voice_sample} + scaled_w;
      mag_w  = sum_w[17] ? 17'(-sum_w) : sum_w[16:0];
      seg_w  = {1'b0, mag_w[16:15]};
      rem7_w = ({3'b000, mag_w[14:0]} << 3) - {3'b000, mag_w[14:0]};
   end

   // knee: 7/8 remainder shifted 3 more bits per segment plus base
   always_comb begin
      case (seg_w)
         3'd0:    shifted_w = rem7_w >> 3;
         3'd1:    shifted_w = rem7_w >> 6;
         3'd2:    shifted_w = rem7_w >> 9;
         3'd3:    shifted_w = rem7_w >> 12;
         default: shifted_w = rem7_w >> 15;
      endcase
      res_w        = vmmf_pkg::knee_base(seg_w) + shifted_w[15:0];
      mixed_sample = sum_w[17] ? -$signed(res_w) : $signed(res_w);
   end

endmodule

`default_nettype wire

// ===== sv/vmmf_fade.sv =====
`default_nettype none

module vmmf_fade (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vmmf_pkg::fade_ctl_type ctl,
   input  wire logic [15:0]            fade_step,
   output logic [15:0]                 gain_now,
   output vmmf_pkg::fade_sts_type      sts_next
);

   logic [15:0]        gain_ff;
   logic [15:0]        gain_in;
   vmmf_pkg::mode_type mode_ff;
   vmmf_pkg::mode_type mode_in;
   logic [16:0]        gain_up_w;

   // gain and fade state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= vmmf_pkg::GAIN_ONE;
         mode_ff <= vmmf_pkg::MODE_IDLE;
      end else if (ctl.fire) begin
         gain_ff <= gain_in;
         mode_ff <= mode_in;
      end
   end

   // next gain and state for the item in the input stage
   always_comb begin
      gain_up_w = {1'b0, gain_ff} + {1'b0, fade_step};
      gain_in   = gain_ff;
      mode_in   = mode_ff;
      case (ctl.op)
         vmmf_pkg::OP_TICK: begin
            case (mode_ff)
               vmmf_pkg::MODE_IN: begin
                  if (gain_up_w >= {1'b0, vmmf_pkg::GAIN_ONE}) begin
                     gain_in = vmmf_pkg::GAIN_ONE;
                     mode_in = vmmf_pkg::MODE_IDLE;
                  end else begin
                     gain_in = gain_up_w[15:0];
                  end
               end
               vmmf_pkg::MODE_OUT: begin
                  if (gain_ff <= fade_step) begin
                     gain_in = 16'd0;
                     mode_in = vmmf_pkg::MODE_IDLE;
                  end else begin
                     gain_in = gain_ff - fade_step;
                  end
               end
               default: begin
                  gain_in = gain_ff;
               end
            endcase
         end
         vmmf_pkg::OP_FADE_IN: begin
            if (mode_ff == vmmf_pkg::MODE_IDLE) begin
               gain_in = vmmf_pkg::GAIN_HALF;
               mode_in = vmmf_pkg::MODE_IN;
            end
         end
         vmmf_pkg::OP_FADE_OUT: begin
            if (mode_ff == vmmf_pkg::MODE_IDLE) begin
               gain_in = vmmf_pkg::GAIN_ONE;
               mode_in = vmmf_pkg::MODE_OUT;
            end
         end
         default: begin
            gain_in = gain_ff;
         end
      endcase
      gain_now      = gain_ff;
      sts_next.gain = gain_in;
      sts_next.mode = mode_in;
   end

endmodule

`default_nettype wire

// ===== sv/voice_music_mixer_with_fade_top.sv =====
// Voice and music mixer with fade gain and soft clip.
// req channel: one item per handshake; tuser selects mix, fade tick,
// start fade in or start fade out; tdata carries the voice and music samples.
// rsp channel: exactly one item per request, in order, with the clipped mix
// (zero for fade items), the music gain after the item and the fade mode.
// csr channel: writes fade_step (q1.15 gain change per tick); csr_ready is
// always high, writes are meant to happen while no item is in flight.
// Flow: an accepted item sits in the input register and moves to the result
// register once that register is empty or being read; rsp_tvalid is then high.
// Throughput: one item per cycle while rsp_tready is high; the path between the two
// registers is one 16x17 multiply, a few adds and the knee table lookup.
// Reset: synchronous; gain returns to unity, fade mode to idle, fade_step
// to 298, and both stages are emptied.
// Stall: when rsp_tready is low with a result held, the input register keeps
// any item it holds and req_tready drops while it holds one; no item is lost or repeated.
`default_nettype none

module voice_music_mixer_with_fade_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request item
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // voice_sample[15:0], music_sample[31:16]
   input  wire logic [1:0]  req_tuser,   // operation[1:0]
   // result item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // mixed_sample[15:0], gain[31:16],
                                         // fade_mode[33:32], zero[39:34]
   // fade step register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   logic                   in_vld_ff;
   logic                   in_vld_in;
   logic [31:0]            in_data_ff;
   vmmf_pkg::op_type       in_op_ff;
   logic                   out_vld_ff;
   logic                   out_vld_in;
   logic [15:0]            out_mix_ff;
   vmmf_pkg::fade_sts_type out_sts_ff;
   logic [15:0]            step_ff;
   logic                   advance_w;
   logic                   move_w;
   logic [15:0]            gain_now_w;
   logic signed [15:0]     mixed_w;
   vmmf_pkg::fade_ctl_type fade_ctl_w;
   vmmf_pkg::fade_sts_type sts_next_w;

   // handshake between the stages
   always_comb begin
      advance_w  = !out_vld_ff || rsp_tready;
      move_w     = in_vld_ff && advance_w;
      req_tready = !in_vld_ff || advance_w;
      in_vld_in  = (req_tvalid && req_tready) ? 1'b1 : (move_w ? 1'b0 : in_vld_ff);
      out_vld_in = move_w ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);
      csr_ready  = 1'b1;
   end

   // fade step register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= vmmf_pkg::STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         step_ff <= csr_data;
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_op_ff   <= vmmf_pkg::op_type'(req_tuser);
      end
   end

   // gain and fade state
   always_comb begin
      fade_ctl_w.fire = move_w;
      fade_ctl_w.op   = in_op_ff;
   end

   vmmf_fade u_fade (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fade_ctl_w),
      .fade_step (step_ff),
      .gain_now  (gain_now_w),
      .sts_next  (sts_next_w)
   );

   // mix datapath
   vmmf_mix u_mix (
      .voice_sample (in_data_ff[15:0]),
      .music_sample (in_data_ff[31:16]),
      .gain         (gain_now_w),
      .mixed_sample (mixed_w)
   );

   // result register
   always_ff @(posedge clock) begin
      if (move_w) begin
         out_mix_ff <= (in_op_ff == vmmf_pkg::OP_MIX) ? mixed_w : 16'd0;
         out_sts_ff <= sts_next_w;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, out_sts_ff.mode, out_sts_ff.gain, out_mix_ff};

endmodule

`default_nettype wire

// ===== tb/sv/mixer_result_check.sv =====
// watches the request, result and fade step channels, works out the expected
// result of every accepted request item and compares it with the result items
module mixer_result_check
   import vmmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // voice_sample[15:0], music_sample[31:16]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // mixed_sample[15:0], gain[31:16], fade_mode[33:32]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   // one result item as the block should produce it
   typedef struct packed {
      logic [15:0] mixed;
      logic [15:0] gain;
      mode_type    mode;
   } mix_result_type;

   // own copy of the fade state and the step register
   logic [15:0]    gain_now;
   mode_type       mode_now;
   logic [15:0]    step_now;
   mix_result_type due_mixes [$];
   int             mismatches = 0;
   int             matched    = 0;

   always @(posedge clock) begin : watch
      int             voice;
      int             music;
      int             scaled;
      int             total;
      int             mag;
      int             seg;
      int             base;
      int             bent;
      int unsigned    raised;
      mix_result_type due;
      mix_result_type seen;
      if (reset) begin
         gain_now = GAIN_ONE;
         mode_now = MODE_IDLE;
         step_now = STEP_RESET;
         due_mixes.delete();
      end else begin
         // fade step writes should land only while nothing is in flight; the block does not enforce this
         if (csr_valid && csr_ready)
            step_now = csr_data;

         // compare a result item with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen.mixed = rsp_tdata[15:0];
            seen.gain  = rsp_tdata[31:16];
            seen.mode  = mode_type'(rsp_tdata[33:32]);
            matched++;
            if (due_mixes.size() == 0) begin
               $error("result item with nothing expected: mixed_sample %0d gain %0d",
                      $signed(seen.mixed), seen.gain);
               mismatches++;
            end else begin
               due = due_mixes.pop_front();
               if (seen.mixed !== due.mixed) begin
                  $error("mixed_sample: expected %0d, actual %0d",
                         $signed(due.mixed), $signed(seen.mixed));
                  mismatches++;
               end
               if (seen.gain !== due.gain) begin
                  $error("gain: expected %0d, actual %0d", due.gain, seen.gain);
                  mismatches++;
               end
               if (seen.mode !== due.mode) begin
                  $error("fade_mode: expected %0d, actual %0d", due.mode, seen.mode);
                  mismatches++;
               end
            end
         end

         // work out what an accepted request item must give
         if (req_tvalid && req_tready) begin
            due.mixed = 16'd0;
            case (op_type'(req_tuser))
               OP_MIX: begin
                  voice  = $signed(req_tdata[15:0]);
                  music  = $signed(req_tdata[31:16]);
                  // scaled music truncated toward zero
                  scaled = (music * int'(gain_now)) / 32768;
                  total  = voice + scaled;
                  mag    = (total < 0) ? -total : total;
                  seg    = mag >> 15;
                  if (seg > 4)
                     seg = 4;
                  case (seg)
                     0:       base = 0;
                     1:       base = 28672;
                     2:       base = 32256;
                     3:       base = 32704;
                     default: base = 32760;
                  endcase
                  // knee: 7/8 of the remainder, three more bits down per segment
                  bent = base + (((mag & 32767) * 7) >> (seg * 3 + 3));
                  due.mixed = 16'((total < 0) ? -bent : bent);
               end
               OP_TICK: begin
                  if (mode_now == MODE_IN) begin
                     raised = int'(gain_now) + int'(step_now);
                     if (raised >= int'(GAIN_ONE)) begin
                        gain_now = GAIN_ONE;
                        mode_now = MODE_IDLE;
                     end else begin
                        gain_now = 16'(raised);
                     end
                  end else if (mode_now == MODE_OUT) begin
                     if (gain_now <= step_now) begin
                        gain_now = 16'd0;
                        mode_now = MODE_IDLE;
                     end else begin
                        gain_now = gain_now - step_now;
                     end
                  end
               end
               OP_FADE_IN: begin
                  if (mode_now == MODE_IDLE) begin
                     gain_now = GAIN_HALF;
                     mode_now = MODE_IN;
                  end
               end
               OP_FADE_OUT: begin
                  if (mode_now == MODE_IDLE) begin
                     gain_now = GAIN_ONE;
                     mode_now = MODE_OUT;
                  end
               end
            endcase
            due.gain = gain_now;
            due.mode = mode_now;
            due_mixes.push_back(due);
         end
      end
      fail_count <= mismatches;
      pending    <= due_mixes.size();
      checked    <= matched;
   end

endmodule

// ===== tb/sv/tb_voice_music_mixer_with_fade_top.sv =====
module tb_voice_music_mixer_with_fade_top;
   import vmmf_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 100;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // voice_sample[15:0], music_sample[31:16]
   logic [1:0]  req_tuser  = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // mixed_sample[15:0], gain[31:16], fade_mode[33:32]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   int          fail_count;
   int          pending;
   int          checked;
   logic        calm        = 1'b0;
   int unsigned hold_asks   = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;
   int          quiet       = 0;
   int          op_count [4];
   int          step_writes = 0;

   voice_music_mixer_with_fade_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mixer_result_check u_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: random stalls, calm stretches and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         rsp_tready  <= 1'b0;
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("FAIL voice_music_mixer_with_fade_top");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // offer one request item, with random idle cycles in front of it
   task automatic offer(input op_type op, input logic [15:0] voice,
                        input logic [15:0] music);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {music, voice};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      op_count[int'(op)]++;
   endtask

   // random item, weighted towards mixes and ticks, samples now and then at the rails
   task automatic offer_random();
      int          pick;
      op_type      op;
      logic [15:0] voice;
      logic [15:0] music;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         op = OP_MIX;
      else if (pick < 88)
         op = OP_TICK;
      else if (pick < 94)
         op = OP_FADE_IN;
      else
         op = OP_FADE_OUT;
      voice = 16'($urandom);
      music = 16'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0:       voice = 16'h7FFF;
            1:       voice = 16'h8000;
            2:       music = 16'h7FFF;
            default: music = 16'h8000;
         endcase
      end
      offer(op, voice, music);
   endtask

   // stop sending and wait until every expected result item has come
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_step(input logic [15:0] step);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= step;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      step_writes++;
   endtask

   // stimulus
   initial begin : stimulus
      logic [15:0] step;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: rails of the samples, idle tick, ignored starts, fade ends
      offer(OP_MIX, 16'h7FFF, 16'h7FFF);
      offer(OP_MIX, 16'h8000, 16'h8000);
      offer(OP_MIX, 16'h0000, 16'h0000);
      offer(OP_MIX, 16'h7FFF, 16'h8000);
      offer(OP_MIX, 16'h8000, 16'h7FFF);
      offer(OP_MIX, 16'hFFFF, 16'hFFFF);
      offer(OP_MIX, 16'd20000, 16'd20000);
      offer(OP_TICK, 16'h0000, 16'h0000);
      offer(OP_FADE_OUT, 16'h0000, 16'h0000);
      offer(OP_FADE_OUT, 16'h0000, 16'h0000);
      offer(OP_FADE_IN, 16'h0000, 16'h0000);
      offer(OP_TICK, 16'h0000, 16'h0000);
      offer(OP_MIX, 16'h1234, 16'h8000);
      // a step above unity ends the fade out at once, gain clamps at zero
      write_step(16'hFFFF);
      offer(OP_TICK, 16'h0000, 16'h0000);
      offer(OP_MIX, 16'h0000, 16'h7FFF);
      offer(OP_TICK, 16'h0000, 16'h0000);
      offer(OP_FADE_IN, 16'h0000, 16'h0000);
      offer(OP_MIX, 16'hC000, 16'h8000);
      offer(OP_TICK, 16'h0000, 16'h0000);
      offer(OP_MIX, 16'h4000, 16'h7FFF);

      // random phases, one fade step setting each
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       step = STEP_RESET;
            1:       step = 16'd0;
            2:       step = GAIN_ONE;
            3:       step = 16'd1;
            4:       step = 16'hFFFF;
            5:       step = 16'd2000;
            6:       step = 16'($urandom_range(1, 6000));
            default: step = 16'($urandom);
         endcase
         write_step(step);
         calm <= (p == 3);
         // result side holds off while the sender keeps offering
         if (p == 2 || p == 5) begin
            hold_asks <= hold_asks + 1;
            repeat (30) offer(OP_MIX, 16'($urandom), 16'($urandom));
         end
         repeat (120) offer_random();
      end
      calm <= 1'b0;

      settle();
      repeat (6) @(posedge clock);
      $display("covered %0d fade_step settings; items: %0d mix, %0d tick, %0d fade in, %0d fade out",
               step_writes, op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("%0d result items compared, %0d mismatches", checked, fail_count);
      if (fail_count == 0)
         $display("PASS voice_music_mixer_with_fade_top");
      else
         $display("FAIL voice_music_mixer_with_fade_top");
      $finish;
   end

endmodule
